@@ hdl/lbs_pkg.sv @@
// ----------------------------------------------------------------------------
// lbs_pkg
// Types and constants shared by the skinning unit.
// ----------------------------------------------------------------------------
package lbs_pkg;

	localparam int unsigned MAT_WORDS = 12;

	typedef enum logic [1:0] {
		OP_POSE = 2'd0,
		OP_BIND = 2'd1,
		OP_SKIN = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [7:0]         joint;
		logic [3:0]         element;
		logic signed [31:0] value;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [15:0]        weight;
		logic               last_influence;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MAC,
		ST_ROW,
		ST_ACC,
		ST_OUT
	} state_t;

	// saturate a 49-bit row sum to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [48:0] x);
		logic signed [48:0] hi;
		logic signed [48:0] lo;
		hi = 49'sh0_0000_7FFF_FFFF;
		lo = -49'sh0_0000_8000_0000;
		if (x > hi) return 32'sh7FFF_FFFF;
		else if (x < lo) return 32'sh8000_0000;
		else return x[31:0];
	endfunction

endpackage

@@ hdl/linear_blend_skinning.sv @@
// ----------------------------------------------------------------------------
// linear_blend_skinning
// Two-stage affine transform of a rest vertex, weighted and accumulated.
// ----------------------------------------------------------------------------
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready  | in_item_t
// out     | out | out_valid / out_ready| out_item_t
//
// Load items and unused operations are handled in the idle state. Each
// influence walks 24 matrix words (bind then pose), each word going through
// a read state and a multiply-add state with one multiplier, plus a row
// state per row to saturate, then accumulate and emit states before the next
// item is taken. Zero-weight, stopped or out-of-range influences skip to emit.
// An emitted item waits in the output register; a new item is taken only
// once it is gone. Reset clears control and the accumulator; the tables hold
// garbage until written.
// ----------------------------------------------------------------------------
module linear_blend_skinning import lbs_pkg::*; #(
	parameter int unsigned MAX_JOINTS = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);
	localparam int unsigned DEPTH = MAX_JOINTS * MAT_WORDS;
	localparam int unsigned AW = $clog2(DEPTH);

	state_t state_q, state_d;
	in_item_t item_q;
	logic [AW-1:0] base_q;
	logic       phase_q;       // 0 bind, 1 pose
	logic [1:0] row_q, col_q;
	logic signed [31:0] vec_q [3];
	logic signed [31:0] res_q [3];
	logic signed [48:0] sum_q;
	logic signed [47:0] acc_q [3];
	logic stopped_q;

	logic acc_in;
	logic [AW-1:0] raddr;
	logic [31:0] pose_rd, bind_rd;
	logic signed [31:0] word;
	logic signed [63:0] prod;
	logic signed [48:0] rnd;
	logic out_busy;

	assign in_ready = (state_q == ST_IDLE) && !out_busy;
	assign acc_in = in_valid && in_ready;
	assign out_busy = out_valid;

	// table write on load items, otherwise read the current word
	logic wr_pose, wr_bind;
	logic [AW-1:0] waddr;
	logic [AW+3:0] wfull;
	assign wfull = (AW+4)'(in_item.joint) * (AW+4)'(MAT_WORDS) + (AW+4)'(in_item.element);
	assign waddr = wfull[AW-1:0];
	always_comb begin
		wr_pose = acc_in && in_item.operation == OP_POSE && in_item.element < 4'd12
			&& 32'(in_item.joint) < MAX_JOINTS;
		wr_bind = acc_in && in_item.operation == OP_BIND && in_item.element < 4'd12
			&& 32'(in_item.joint) < MAX_JOINTS;
	end
	assign raddr = base_q + AW'({row_q, col_q});

	lbs_mat_mem #(.DEPTH(DEPTH), .AW(AW)) u_pose (
		.clk(clk), .we(wr_pose), .addr(wr_pose ? waddr : raddr),
		.wdata(in_item.value), .rdata(pose_rd)
	);
	lbs_mat_mem #(.DEPTH(DEPTH), .AW(AW)) u_bind (
		.clk(clk), .we(wr_bind), .addr(wr_bind ? waddr : raddr),
		.wdata(in_item.value), .rdata(bind_rd)
	);

	// one product per word, rounded to q16.16
	assign word = phase_q ? pose_rd : bind_rd;
	assign prod = 64'(word) * 64'(vec_q[col_q]);
	assign rnd = 49'((prod + 64'sd32768) >>> 16);

	// weighted term per lane
	logic signed [48:0] wprod [3];
	logic signed [49:0] asum [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			wprod[k] = 49'((64'(res_q[k]) * 64'($signed({1'b0, item_q.weight}))
				+ 64'sd16384) >>> 15);
			asum[k] = 50'(acc_q[k]) + 50'(wprod[k]);
		end
	end

	function automatic logic signed [47:0] sat48(input logic signed [49:0] x);
		if (x > 50'sh0_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
		else if (x < -50'sh0_8000_0000_0000) return 48'sh8000_0000_0000;
		else return x[47:0];
	endfunction

	function automatic logic signed [31:0] sat_acc(input logic signed [47:0] x);
		if (x > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
		else if (x < -48'sh0000_8000_0000) return 32'sh8000_0000;
		else return x[31:0];
	endfunction

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (acc_in && in_item.operation == OP_SKIN) begin
				if (stopped_q || in_item.weight == 16'd0 ||
					32'(in_item.joint) >= MAX_JOINTS) state_d = ST_OUT;
				else state_d = ST_READ;
			end
			ST_READ: state_d = ST_MAC;
			ST_MAC: if (col_q == 2'd3) state_d = ST_ROW;
				else state_d = ST_READ;
			ST_ROW: if (row_q == 2'd2 && phase_q) state_d = ST_ACC;
				else state_d = ST_READ;
			ST_ACC: state_d = ST_OUT;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stopped_q <= 1'b0;
			out_valid <= 1'b0;
			phase_q <= 1'b0;
			row_q <= '0;
			col_q <= '0;
			for (int k = 0; k < 3; k++) acc_q[k] <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (acc_in) begin
					item_q <= in_item;
					base_q <= AW'(wfull - (AW+4)'(in_item.element));
					vec_q[0] <= in_item.pos_x;
					vec_q[1] <= in_item.pos_y;
					vec_q[2] <= in_item.pos_z;
					phase_q <= 1'b0;
					row_q <= '0;
					col_q <= '0;
					if (in_item.operation == OP_SKIN && !stopped_q && in_item.weight == 16'd0)
						stopped_q <= 1'b1;
				end
				ST_READ: ;
				ST_MAC: begin
					if (col_q == 2'd0) sum_q <= rnd;
					else if (col_q == 2'd3) sum_q <= sum_q + 49'(word);
					else sum_q <= sum_q + rnd;
					col_q <= col_q + 2'd1;
				end
				ST_ROW: begin
					res_q[row_q] <= sat32(sum_q);
					col_q <= '0;
					if (row_q == 2'd2) begin
						row_q <= '0;
						if (!phase_q) begin
							phase_q <= 1'b1;
							vec_q[0] <= res_q[0];
							vec_q[1] <= res_q[1];
							vec_q[2] <= sat32(sum_q);
						end
					end else row_q <= row_q + 2'd1;
				end
				ST_ACC: for (int k = 0; k < 3; k++) acc_q[k] <= sat48(asum[k]);
				ST_OUT: if (item_q.last_influence) begin
					out_valid <= 1'b1;
					out_item.out_x <= sat_acc(acc_q[0]);
					out_item.out_y <= sat_acc(acc_q[1]);
					out_item.out_z <= sat_acc(acc_q[2]);
					for (int k = 0; k < 3; k++) acc_q[k] <= '0;
					stopped_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("item taken while output pending");
	a_out_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_OUT) else $error("stray output");
	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> acc_q[0] == '0 && !stopped_q) else $error("acc not cleared");
`endif
endmodule

@@ hdl/lbs_mat_mem.sv @@
// ----------------------------------------------------------------------------
// lbs_mat_mem
// Single-port matrix word store, registered read.
// ----------------------------------------------------------------------------
module lbs_mat_mem #(
	parameter int unsigned DEPTH = 3072,
	parameter int unsigned AW = 12
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     addr,
	input  logic [31:0]       wdata,
	output logic [31:0]       rdata
);
	logic [31:0] mem [DEPTH];

	// write or read one word per cycle
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the skinning unit: joint table loads and weighted vertex influences
// run through a local fixed point predictor, results compared in order.
// ----------------------------------------------------------------------------
module tb_top import lbs_pkg::*; ();

	localparam int NJ = 256;
	localparam int N_RANDOM = 450;
	localparam int WATCHDOG = 20000;
	localparam longint ACC_HI = 64'sd140737488355327;
	localparam longint ACC_LO = -64'sd140737488355328;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;

	linear_blend_skinning dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [31:0] pose_words [NJ*MAT_WORDS];
	logic [31:0] bind_words [NJ*MAT_WORDS];
	bit          written    [NJ];
	longint      blend_sum  [3];
	bit          vertex_stopped;
	out_item_t   skinned_q [$];

	int  errors = 0;
	int  n_sent = 0;
	int  n_got = 0;
	int  n_idle = 0;
	bit  sending_done = 0;
	bit  hold_off = 0;

	function automatic longint floor_sh(longint x, int s);
		return x >>> s;
	endfunction

	function automatic longint clip(longint x, longint lo, longint hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	// one 3x4 affine product with rounding and 32-bit saturation
	task automatic affine(input bit use_pose, input int base, input longint v[3],
			output longint r[3]);
		longint s;
		longint m;
		for (int row = 0; row < 3; row++) begin
			m = use_pose ? longint'($signed(pose_words[base+row*4+3]))
				: longint'($signed(bind_words[base+row*4+3]));
			s = m;
			for (int c = 0; c < 3; c++) begin
				m = use_pose ? longint'($signed(pose_words[base+row*4+c]))
					: longint'($signed(bind_words[base+row*4+c]));
				s += floor_sh(m * v[c] + 32768, 16);
			end
			r[row] = clip(s, -64'sd2147483648, 64'sd2147483647);
		end
	endtask

	task automatic predict_skin(input in_item_t it);
		longint p[3];
		longint q[3];
		longint w[3];
		out_item_t o;
		if (it.operation == OP_POSE || it.operation == OP_BIND) begin
			if (it.element < MAT_WORDS) begin
				if (it.operation == OP_POSE) pose_words[it.joint*MAT_WORDS+it.element] = it.value;
				else bind_words[it.joint*MAT_WORDS+it.element] = it.value;
			end
			return;
		end
		if (it.operation != OP_SKIN) return;
		if (!vertex_stopped) begin
			if (it.weight == 0) vertex_stopped = 1;
			else begin
				p[0] = it.pos_x; p[1] = it.pos_y; p[2] = it.pos_z;
				affine(0, it.joint*MAT_WORDS, p, q);
				affine(1, it.joint*MAT_WORDS, q, w);
				for (int k = 0; k < 3; k++)
					blend_sum[k] = clip(blend_sum[k] +
						floor_sh(w[k] * longint'(it.weight) + 16384, 15), ACC_LO, ACC_HI);
			end
		end
		if (!it.last_influence) return;
		o.out_x = 32'(clip(blend_sum[0], -64'sd2147483648, 64'sd2147483647));
		o.out_y = 32'(clip(blend_sum[1], -64'sd2147483648, 64'sd2147483647));
		o.out_z = 32'(clip(blend_sum[2], -64'sd2147483648, 64'sd2147483647));
		skinned_q.push_back(o);
		blend_sum = '{0, 0, 0};
		vertex_stopped = 0;
	endtask

	// drive one item, with a random gap before it
	task automatic send_item(input in_item_t it);
		int gap;
		gap = $urandom_range(0, 5);
		if (n_sent % 80 > 60) gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		predict_skin(it);
		in_item <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		n_sent++;
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0001_0000;
			3: return 32'(int'($urandom_range(0, 262143)) - 131072);
			default: return $urandom;
		endcase
	endfunction

	function automatic in_item_t skin(input logic [7:0] j, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] z, input logic [15:0] w,
			input logic last);
		in_item_t it;
		it = '0;
		it.operation = OP_SKIN; it.joint = j; it.pos_x = x; it.pos_y = y; it.pos_z = z;
		it.weight = w; it.last_influence = last;
		it.value = $urandom; it.element = 4'($urandom);
		return it;
	endfunction

	task automatic load_joint(input int j, input bit ident);
		in_item_t it;
		for (int e = 0; e < 2 * MAT_WORDS; e++) begin
			it = '0;
			it.operation = e < MAT_WORDS ? OP_POSE : OP_BIND;
			it.joint = 8'(j);
			it.element = 4'(e % MAT_WORDS);
			if (ident) it.value = ((e % 12) % 5 == 0) ? 32'h0001_0000 : 32'h0;
			else it.value = rand_word();
			send_item(it);
		end
		written[j] = 1;
	endtask

	// stimulus
	in_item_t directed [$];
	initial begin
		in_item_t it;
		int j;
		int ninf;
		for (int i = 0; i < NJ * MAT_WORDS; i++) begin
			pose_words[i] = '0;
			bind_words[i] = '0;
		end
		blend_sum = '{0, 0, 0};
		vertex_stopped = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// identity on joint 0, random words on joint 255
		load_joint(0, 1);
		load_joint(255, 0);
		// ignored writes: element out of range, operation with no meaning
		it = '0; it.operation = OP_POSE; it.element = 4'd15; it.value = 32'hFFFF_FFFF;
		directed.push_back(it);
		it = '0; it.operation = OP_NONE; it.weight = 16'hFFFF; it.last_influence = 1;
		directed.push_back(it);
		directed.push_back(skin(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 16'd32768, 1));
		directed.push_back(skin(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 0));
		directed.push_back(skin(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1));
		directed.push_back(skin(255, 32'h0003_0000, 32'hFFFF_0000, 32'h0, 16'd16384, 0));
		directed.push_back(skin(0, 32'h0001_8000, 32'h0, 32'h0, 16'd0, 0));
		directed.push_back(skin(255, 32'h0003_0000, 32'h0, 32'h0, 16'd32768, 1));
		directed.push_back(skin(0, 32'h0002_0000, 32'h0, 32'h0, 16'd0, 1));
		directed.push_back(skin(255, 32'hFFFF_FFFF, 32'h0, 32'h1, 16'd1, 1));
		foreach (directed[i]) send_item(directed[i]);
		// long receiver hold-off while items keep coming
		hold_off = 1;
		for (int i = 0; i < 6; i++)
			send_item(skin(0, 32'(i) << 16, 32'h0, 32'h0, 16'd32768, 1));
		hold_off = 0;
		// random vertices, with occasional table reloads and noise
		for (j = 1; j < 8; j++) load_joint(j, 0);
		while (n_sent < N_RANDOM) begin
			if ($urandom_range(0, 30) == 0) load_joint($urandom_range(1, 7), $urandom_range(0, 1));
			if ($urandom_range(0, 9) == 0) begin
				it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
				if (it.operation == OP_SKIN) it.operation = OP_NONE;
				if (!written[it.joint]) it.operation = OP_NONE;
				send_item(it);
			end
			ninf = $urandom_range(1, 4);
			for (int k = 0; k < ninf; k++) begin
				j = $urandom_range(0, 3) == 0 ? 255 : $urandom_range(0, 7);
				send_item(skin(8'(j), rand_word(), rand_word(), rand_word(),
					$urandom_range(0, 7) == 0 ? 16'd0 :
					($urandom_range(0, 5) == 0 ? 16'($urandom) : 16'($urandom_range(1, 32768))),
					k == ninf - 1));
			end
		end
		in_valid <= 1'b0;
		sending_done = 1;
	end

	// receiver: random stalls, one long hold-off
	initial begin
		int wait_c;
		int long_c;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off && long_c < 300) begin
				out_ready <= 1'b0;
				long_c++;
			end else if (wait_c > 0) begin
				out_ready <= 1'b0;
				wait_c--;
			end else begin
				out_ready <= 1'b1;
				if (out_valid && out_ready) wait_c = $urandom_range(0, 5);
			end
		end
	end

	// output comparison
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && out_ready) begin
			n_got++;
			if (skinned_q.size() == 0) begin
				$display("%0t unexpected result x=%h y=%h z=%h", $time,
					out_item.out_x, out_item.out_y, out_item.out_z);
				errors++;
			end else begin
				e = skinned_q.pop_front();
				if (e.out_x !== out_item.out_x) begin
					$display("%0t out_x expected %h actual %h", $time, e.out_x, out_item.out_x);
					errors++;
				end
				if (e.out_y !== out_item.out_y) begin
					$display("%0t out_y expected %h actual %h", $time, e.out_y, out_item.out_y);
					errors++;
				end
				if (e.out_z !== out_item.out_z) begin
					$display("%0t out_z expected %h actual %h", $time, e.out_z, out_item.out_z);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) n_idle <= 0;
		else n_idle <= n_idle + 1;
	end

	initial begin
		wait (n_idle >= WATCHDOG);
		$display("watchdog expired, %0d results still expected", skinned_q.size());
		$display("FAILURE");
		$finish;
	end

	// end of run
	initial begin
		wait (sending_done);
		wait (skinned_q.size() == 0);
		repeat (100) @(posedge clk);
		if (skinned_q.size() != 0) begin
			$display("%0d expected results never arrived", skinned_q.size());
			errors++;
		end
		$display("sent %0d items (loads, influences, ignored ops), checked %0d vertices",
			n_sent, n_got);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", errors);
			$display("FAILURE");
		end
		$finish;
	end
endmodule
